@@ src/pwl_lin_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piecewise-linear temperature linearizer: shared definitions
// Widths, command and register codes, reset table, and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package pwl_lin_pkg;

   localparam int MAX_POINTS = 8;
   localparam int RAW_W      = 16;
   localparam int TIP_W      = 13;
   localparam int AMB_W      = 12;
   localparam int REF_W      = 10;
   localparam int CNT_W      = 4;
   localparam int IDX_W      = 3;
   localparam int CMD_W      = 2;
   localparam int PROD_W     = RAW_W + TIP_W;
   localparam int SUM_W      = 16;
   localparam int STEP_W     = 4;
   localparam int DIV_STEPS  = TIP_W;

   typedef logic [RAW_W-1:0]         raw_type;
   typedef logic [TIP_W-1:0]         tip_type;
   typedef logic signed [AMB_W-1:0]  amb_type;
   typedef logic [REF_W-1:0]         ref_type;
   typedef logic [CNT_W-1:0]         cnt_type;
   typedef logic [IDX_W-1:0]         idx_type;
   typedef logic [CMD_W-1:0]         cmd_type;
   typedef logic [PROD_W-1:0]        prod_type;
   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef logic [STEP_W-1:0]        step_type;
   typedef logic [0:0]               csr_idx_type;

   localparam cmd_type CMD_CONVERT     = 2'd0;
   localparam cmd_type CMD_WRITE_POINT = 2'd1;
   localparam cmd_type CMD_SET_COUNT   = 2'd2;

   localparam csr_idx_type REG_REF_AMBIENT = 1'b0;
   localparam csr_idx_type REG_MAX_TIP     = 1'b1;

   localparam ref_type RESET_REF_AMBIENT = 10'd250;
   localparam tip_type RESET_MAX_TIP     = 13'd4500;
   localparam cnt_type RESET_USED        = 4'd8;

   localparam raw_type RESET_RAW [MAX_POINTS] = '{
      16'd420, 16'd1160, 16'd1660, 16'd2180, 16'd2720, 16'd3290, 16'd3890, 16'd4520
   };
   localparam tip_type RESET_TIP [MAX_POINTS] = '{
      13'd250, 13'd1000, 13'd1500, 13'd2000, 13'd2500, 13'd3000, 13'd3500, 13'd4000
   };

   typedef struct packed {
      logic    load;
      logic    exec;
      idx_type rd_addr;
      logic    take_prev;
      logic    take_end;
      logic    seg_ld;
      logic    mul;
      logic    div_step;
      logic    seg_fin;
      logic    adj;
   } dp_cmd_type;

   typedef struct packed {
      logic    is_convert;
      logic    table_ok;
      logic    rd_le;
      logic    rd_ge;
      logic    seg_flat;
      idx_type last_idx;
   } dp_status_type;

endpackage

@@ src/piecewise_linear_temp_linearizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piecewise-linear temperature linearizer
// Converts a raw thermocouple reading to tip temperature in tenths of a
// degree from a table of up to eight points, and handles table writes and
// point count updates.
//
//   Channel   Signals                                  Handshake
//   request   start, busy, req_*                       start & !busy
//   response  rsp_valid, rsp_tip_temp, rsp_ok          rsp_valid, one cycle
//   csr       csr_valid, csr_ready, csr_index, csr_data csr_valid & csr_ready
//
// A table write or count update executes in the decode state and strobes
// from the done state. A conversion clamps at the first or last point, or
// scans for the segment's upper point; a flat segment takes that point, else
// it runs the multiply, the 13-step serial divide and the segment finish.
// busy stays high through the strobe cycle; results cannot be held off.
// Reset is synchronous and restores the default curve, marked invalid.
// ----------------------------------------------------------------------------
module piecewise_linear_temp_linearizer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  pwl_lin_pkg::cmd_type     req_cmd,
   input  pwl_lin_pkg::raw_type     req_raw_reading,
   input  pwl_lin_pkg::amb_type     req_ambient_temp,
   input  pwl_lin_pkg::idx_type     req_point_index,
   input  pwl_lin_pkg::tip_type     req_point_temp,
   input  pwl_lin_pkg::cnt_type     req_new_point_count,
   input  logic                     req_new_valid,
   output logic                     rsp_valid,
   output pwl_lin_pkg::tip_type     rsp_tip_temp,
   output logic                     rsp_ok,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  pwl_lin_pkg::csr_idx_type csr_index,
   input  pwl_lin_pkg::tip_type     csr_data
);

   pwl_lin_pkg::dp_cmd_type    ctl;
   pwl_lin_pkg::dp_status_type sts;

   assign csr_ready = 1'b1;

   pwl_lin_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .ctl       (ctl),
      .sts       (sts)
   );

   pwl_lin_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .ctl                 (ctl),
      .sts                 (sts),
      .req_cmd             (req_cmd),
      .req_raw_reading     (req_raw_reading),
      .req_ambient_temp    (req_ambient_temp),
      .req_point_index     (req_point_index),
      .req_point_temp      (req_point_temp),
      .req_new_point_count (req_new_point_count),
      .req_new_valid       (req_new_valid),
      .csr_write           (csr_valid && csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .rsp_tip_temp        (rsp_tip_temp),
      .rsp_ok              (rsp_ok)
   );

endmodule

@@ src/pwl_lin_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piecewise-linear temperature linearizer: datapath
// Holds the point table, the configuration registers and the working
// registers for the segment search, the multiply, the serial divide and the
// final ambient correction and clamp.
// ----------------------------------------------------------------------------
module pwl_lin_dp (
   input  logic                       clock,
   input  logic                       reset,
   input  pwl_lin_pkg::dp_cmd_type    ctl,
   output pwl_lin_pkg::dp_status_type sts,
   input  pwl_lin_pkg::cmd_type       req_cmd,
   input  pwl_lin_pkg::raw_type       req_raw_reading,
   input  pwl_lin_pkg::amb_type       req_ambient_temp,
   input  pwl_lin_pkg::idx_type       req_point_index,
   input  pwl_lin_pkg::tip_type       req_point_temp,
   input  pwl_lin_pkg::cnt_type       req_new_point_count,
   input  logic                       req_new_valid,
   input  logic                       csr_write,
   input  pwl_lin_pkg::csr_idx_type   csr_index,
   input  pwl_lin_pkg::tip_type       csr_data,
   output pwl_lin_pkg::tip_type       rsp_tip_temp,
   output logic                       rsp_ok
);

   pwl_lin_pkg::raw_type point_raw_ff [pwl_lin_pkg::MAX_POINTS];
   pwl_lin_pkg::raw_type point_raw_in [pwl_lin_pkg::MAX_POINTS];
   pwl_lin_pkg::tip_type point_tip_ff [pwl_lin_pkg::MAX_POINTS];
   pwl_lin_pkg::tip_type point_tip_in [pwl_lin_pkg::MAX_POINTS];
   pwl_lin_pkg::cnt_type used_ff, used_in;
   logic                 valid_ff, valid_in;
   pwl_lin_pkg::ref_type ref_ff, ref_in;
   pwl_lin_pkg::tip_type max_ff, max_in;

   pwl_lin_pkg::cmd_type cmd_ff, cmd_in;
   pwl_lin_pkg::raw_type raw_ff, raw_in;
   pwl_lin_pkg::amb_type amb_ff, amb_in;
   pwl_lin_pkg::idx_type idx_ff, idx_in;
   pwl_lin_pkg::tip_type ptemp_ff, ptemp_in;
   pwl_lin_pkg::cnt_type cnt_ff, cnt_in;
   logic                 nv_ff, nv_in;

   pwl_lin_pkg::raw_type prev_raw_ff, prev_raw_in;
   pwl_lin_pkg::tip_type prev_tip_ff, prev_tip_in;
   pwl_lin_pkg::raw_type span_ff, span_in;
   pwl_lin_pkg::raw_type off_ff, off_in;
   pwl_lin_pkg::tip_type dmag_ff, dmag_in;
   logic                 neg_ff, neg_in;
   pwl_lin_pkg::tip_type base_ff, base_in;
   pwl_lin_pkg::raw_type rem_ff, rem_in;
   pwl_lin_pkg::tip_type dvd_ff, dvd_in;
   pwl_lin_pkg::tip_type t_ff, t_in;
   pwl_lin_pkg::tip_type rsp_tip_ff, rsp_tip_in;
   logic                 rsp_ok_ff, rsp_ok_in;

   pwl_lin_pkg::raw_type          rd_raw;
   pwl_lin_pkg::tip_type          rd_tip;
   logic [pwl_lin_pkg::RAW_W:0]   span_w;
   logic [pwl_lin_pkg::RAW_W:0]   off_w;
   logic [pwl_lin_pkg::TIP_W:0]   dtemp_w;
   pwl_lin_pkg::prod_type         prod_w;
   logic [pwl_lin_pkg::RAW_W:0]   trial_w;
   logic [pwl_lin_pkg::RAW_W:0]   diff_w;
   logic                          trial_ge;
   pwl_lin_pkg::sum_type          sum_w;

   assign rd_raw  = point_raw_ff[ctl.rd_addr];
   assign rd_tip  = point_tip_ff[ctl.rd_addr];
   assign span_w  = {1'b0, rd_raw} - {1'b0, prev_raw_ff};
   assign off_w   = {1'b0, raw_ff} - {1'b0, prev_raw_ff};
   assign dtemp_w = {1'b0, rd_tip} - {1'b0, prev_tip_ff};
   assign prod_w  = pwl_lin_pkg::prod_type'(dmag_ff) * pwl_lin_pkg::prod_type'(off_ff);
   assign trial_w  = {rem_ff, dvd_ff[pwl_lin_pkg::TIP_W-1]};
   assign trial_ge = trial_w >= {1'b0, span_ff};
   assign diff_w   = trial_w - {1'b0, span_ff};
   assign sum_w = pwl_lin_pkg::sum_type'(t_ff) + pwl_lin_pkg::sum_type'(amb_ff)
                  - pwl_lin_pkg::sum_type'(ref_ff);

   always_comb begin
      sts.is_convert = cmd_ff == pwl_lin_pkg::CMD_CONVERT;
      sts.table_ok   = valid_ff && (used_ff != '0);
      sts.rd_le      = raw_ff <= rd_raw;
      sts.rd_ge      = raw_ff >= rd_raw;
      sts.seg_flat   = span_w[pwl_lin_pkg::RAW_W] || (span_w == '0);
      sts.last_idx   = pwl_lin_pkg::idx_type'(used_ff - 1'b1);
   end

   always_comb begin
      point_raw_in = point_raw_ff;
      point_tip_in = point_tip_ff;
      used_in      = used_ff;
      valid_in     = valid_ff;
      ref_in       = ref_ff;
      max_in       = max_ff;
      cmd_in       = cmd_ff;
      raw_in       = raw_ff;
      amb_in       = amb_ff;
      idx_in       = idx_ff;
      ptemp_in     = ptemp_ff;
      cnt_in       = cnt_ff;
      nv_in        = nv_ff;
      prev_raw_in  = prev_raw_ff;
      prev_tip_in  = prev_tip_ff;
      span_in      = span_ff;
      off_in       = off_ff;
      dmag_in      = dmag_ff;
      neg_in       = neg_ff;
      base_in      = base_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      t_in         = t_ff;
      rsp_tip_in   = rsp_tip_ff;
      rsp_ok_in    = rsp_ok_ff;

      if (csr_write) begin
         unique case (csr_index)
            pwl_lin_pkg::REG_REF_AMBIENT: ref_in = csr_data[pwl_lin_pkg::REF_W-1:0];
            pwl_lin_pkg::REG_MAX_TIP:     max_in = csr_data;
            default:                      max_in = max_ff;
         endcase
      end

      if (ctl.load) begin
         cmd_in   = req_cmd;
         raw_in   = req_raw_reading;
         amb_in   = req_ambient_temp;
         idx_in   = req_point_index;
         ptemp_in = req_point_temp;
         cnt_in   = req_new_point_count;
         nv_in    = req_new_valid;
      end

      if (ctl.exec) begin
         rsp_tip_in = '0;
         rsp_ok_in  = 1'b0;
         unique case (cmd_ff)
            pwl_lin_pkg::CMD_WRITE_POINT: begin
               point_raw_in[idx_ff] = raw_ff;
               point_tip_in[idx_ff] = ptemp_ff;
               rsp_ok_in            = 1'b1;
            end
            pwl_lin_pkg::CMD_SET_COUNT: begin
               if (int'(cnt_ff) <= pwl_lin_pkg::MAX_POINTS) begin
                  used_in   = cnt_ff;
                  valid_in  = nv_ff;
                  rsp_ok_in = nv_ff;
               end
            end
            default: rsp_ok_in = 1'b0;
         endcase
      end

      if (ctl.take_prev) begin
         prev_raw_in = rd_raw;
         prev_tip_in = rd_tip;
      end

      if (ctl.take_end) begin
         t_in = rd_tip;
      end

      if (ctl.seg_ld) begin
         span_in = span_w[pwl_lin_pkg::RAW_W-1:0];
         off_in  = off_w[pwl_lin_pkg::RAW_W] ? '0 : off_w[pwl_lin_pkg::RAW_W-1:0];
         neg_in  = dtemp_w[pwl_lin_pkg::TIP_W];
         dmag_in = dtemp_w[pwl_lin_pkg::TIP_W] ? pwl_lin_pkg::tip_type'(-dtemp_w)
                                               : dtemp_w[pwl_lin_pkg::TIP_W-1:0];
         base_in = prev_tip_ff;
      end

      if (ctl.mul) begin
         rem_in = prod_w[pwl_lin_pkg::PROD_W-1:pwl_lin_pkg::TIP_W];
         dvd_in = prod_w[pwl_lin_pkg::TIP_W-1:0];
      end

      if (ctl.div_step) begin
         rem_in = trial_ge ? diff_w[pwl_lin_pkg::RAW_W-1:0] : trial_w[pwl_lin_pkg::RAW_W-1:0];
         dvd_in = {dvd_ff[pwl_lin_pkg::TIP_W-2:0], trial_ge};
      end

      if (ctl.seg_fin) begin
         t_in = neg_ff ? base_ff - dvd_ff : base_ff + dvd_ff;
      end

      if (ctl.adj) begin
         rsp_ok_in = 1'b1;
         if (sum_w < 0) begin
            rsp_tip_in = '0;
         end else if (sum_w > pwl_lin_pkg::sum_type'(max_ff)) begin
            rsp_tip_in = max_ff;
         end else begin
            rsp_tip_in = sum_w[pwl_lin_pkg::TIP_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pwl_lin_pkg::MAX_POINTS; i++) begin
            point_raw_ff[i] <= pwl_lin_pkg::RESET_RAW[i];
            point_tip_ff[i] <= pwl_lin_pkg::RESET_TIP[i];
         end
         used_ff  <= pwl_lin_pkg::RESET_USED;
         valid_ff <= 1'b0;
         ref_ff   <= pwl_lin_pkg::RESET_REF_AMBIENT;
         max_ff   <= pwl_lin_pkg::RESET_MAX_TIP;
      end else begin
         point_raw_ff <= point_raw_in;
         point_tip_ff <= point_tip_in;
         used_ff      <= used_in;
         valid_ff     <= valid_in;
         ref_ff       <= ref_in;
         max_ff       <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      raw_ff      <= raw_in;
      amb_ff      <= amb_in;
      idx_ff      <= idx_in;
      ptemp_ff    <= ptemp_in;
      cnt_ff      <= cnt_in;
      nv_ff       <= nv_in;
      prev_raw_ff <= prev_raw_in;
      prev_tip_ff <= prev_tip_in;
      span_ff     <= span_in;
      off_ff      <= off_in;
      dmag_ff     <= dmag_in;
      neg_ff      <= neg_in;
      base_ff     <= base_in;
      rem_ff      <= rem_in;
      dvd_ff      <= dvd_in;
      t_ff        <= t_in;
      rsp_tip_ff  <= rsp_tip_in;
      rsp_ok_ff   <= rsp_ok_in;
   end

   assign rsp_tip_temp = rsp_tip_ff;
   assign rsp_ok       = rsp_ok_ff;

endmodule

@@ src/pwl_lin_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piecewise-linear temperature linearizer: controller
// Sequences command decode, the end point checks, the segment scan, the
// multiply, the serial divide and the final correction, and strobes the
// result.
// ----------------------------------------------------------------------------
module pwl_lin_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   output logic                       rsp_valid,
   output pwl_lin_pkg::dp_cmd_type    ctl,
   input  pwl_lin_pkg::dp_status_type sts
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_FIRST  = 4'd2;
   localparam logic [3:0] S_LAST   = 4'd3;
   localparam logic [3:0] S_SCAN   = 4'd4;
   localparam logic [3:0] S_MUL    = 4'd5;
   localparam logic [3:0] S_DIV    = 4'd6;
   localparam logic [3:0] S_SEG    = 4'd7;
   localparam logic [3:0] S_ADJ    = 4'd8;
   localparam logic [3:0] S_DONE   = 4'd9;

   logic [3:0]            state_ff, state_in;
   pwl_lin_pkg::step_type ctr_ff, ctr_in;

   always_comb begin
      ctl         = '0;
      ctl.rd_addr = ctr_ff[pwl_lin_pkg::IDX_W-1:0];
      state_in    = state_ff;
      ctr_in      = ctr_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.is_convert && sts.table_ok) begin
               state_in = S_FIRST;
            end else begin
               ctl.exec = 1'b1;
               state_in = S_DONE;
            end
         end
         S_FIRST: begin
            ctl.rd_addr   = '0;
            ctl.take_prev = 1'b1;
            if (sts.rd_le) begin
               ctl.take_end = 1'b1;
               state_in     = S_ADJ;
            end else begin
               state_in = S_LAST;
            end
         end
         S_LAST: begin
            ctl.rd_addr = sts.last_idx;
            if (sts.rd_ge) begin
               ctl.take_end = 1'b1;
               state_in     = S_ADJ;
            end else begin
               ctr_in   = pwl_lin_pkg::step_type'(1);
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (sts.rd_le) begin
               if (sts.seg_flat) begin
                  ctl.take_end = 1'b1;
                  state_in     = S_ADJ;
               end else begin
                  ctl.seg_ld = 1'b1;
                  state_in   = S_MUL;
               end
            end else begin
               ctl.take_prev = 1'b1;
               ctr_in        = ctr_ff + 1'b1;
            end
         end
         S_MUL: begin
            ctl.mul  = 1'b1;
            ctr_in   = pwl_lin_pkg::step_type'(pwl_lin_pkg::DIV_STEPS);
            state_in = S_DIV;
         end
         S_DIV: begin
            ctl.div_step = 1'b1;
            ctr_in       = ctr_ff - 1'b1;
            if (ctr_ff == pwl_lin_pkg::step_type'(1)) begin
               state_in = S_SEG;
            end
         end
         S_SEG: begin
            ctl.seg_fin = 1'b1;
            state_in    = S_ADJ;
         end
         S_ADJ: begin
            ctl.adj  = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ctr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ctr_ff   <= ctr_in;
      end
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_DONE;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("Result strobe held longer than one cycle.");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("Accepted beat did not raise busy.");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (ctr_ff != '0))
      else $error("Divide step counter ran out inside the divide.");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (ctr_ff != '0 &&
                                ctr_ff[pwl_lin_pkg::IDX_W-1:0] <= sts.last_idx))
      else $error("Segment scan moved past the last used point.");

endmodule

@@ tb/piecewise_linear_temp_linearizer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piecewise-linear temperature linearizer testbench
// Sends convert, point write, count update and illegal commands through the
// start/busy port and checks every strobed result against a local model of
// the point table, the segment interpolation and the ambient correction.
// The reference ambient and the tip clamp are reprogrammed between phases.
// ----------------------------------------------------------------------------
module piecewise_linear_temp_linearizer_test;

   localparam pwl_lin_pkg::cmd_type CMD_UNKNOWN = 2'd3;
   localparam int SETTLE_CYCLES = 30;
   localparam int RESULT_WAIT = 200;
   localparam int RUN_LIMIT_NS = 2_000_000;

   typedef struct packed {
      pwl_lin_pkg::cmd_type cmd;
      pwl_lin_pkg::raw_type raw;
      pwl_lin_pkg::amb_type amb;
      pwl_lin_pkg::idx_type idx;
      pwl_lin_pkg::tip_type ptemp;
      pwl_lin_pkg::cnt_type cnt;
      logic                 nv;
   } lin_cmd_type;

   typedef struct packed {
      pwl_lin_pkg::tip_type tip;
      logic                 ok;
   } tip_reading_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   pwl_lin_pkg::cmd_type     req_cmd = pwl_lin_pkg::CMD_CONVERT;
   pwl_lin_pkg::raw_type     req_raw_reading = '0;
   pwl_lin_pkg::amb_type     req_ambient_temp = '0;
   pwl_lin_pkg::idx_type     req_point_index = '0;
   pwl_lin_pkg::tip_type     req_point_temp = '0;
   pwl_lin_pkg::cnt_type     req_new_point_count = '0;
   logic                     req_new_valid = 1'b0;
   logic                     rsp_valid;
   pwl_lin_pkg::tip_type     rsp_tip_temp;
   logic                     rsp_ok;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   pwl_lin_pkg::csr_idx_type csr_index = pwl_lin_pkg::REG_REF_AMBIENT;
   pwl_lin_pkg::tip_type     csr_data = '0;

   pwl_lin_pkg::raw_type tbl_raw [pwl_lin_pkg::MAX_POINTS];
   pwl_lin_pkg::tip_type tbl_tip [pwl_lin_pkg::MAX_POINTS];
   pwl_lin_pkg::cnt_type tbl_used;
   logic                 tbl_valid;
   pwl_lin_pkg::ref_type ref_amb;
   pwl_lin_pkg::tip_type max_tip;

   lin_cmd_type     pending_cmds [$];
   tip_reading_type expected_readings [$];
   lin_cmd_type     taken;
   tip_reading_type want;
   bit              gaps_on = 1'b1;
   int              idle_left = 0;
   int              mismatches = 0;
   int              checked = 0;
   int              n_convert = 0;
   int              n_point = 0;
   int              n_count = 0;
   int              n_other = 0;
   int              n_csr = 0;

   piecewise_linear_temp_linearizer dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_cmd             (req_cmd),
      .req_raw_reading     (req_raw_reading),
      .req_ambient_temp    (req_ambient_temp),
      .req_point_index     (req_point_index),
      .req_point_temp      (req_point_temp),
      .req_new_point_count (req_new_point_count),
      .req_new_valid       (req_new_valid),
      .rsp_valid           (rsp_valid),
      .rsp_tip_temp        (rsp_tip_temp),
      .rsp_ok              (rsp_ok),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always #5 clock = ~clock;

   task automatic flag_mismatch(string what);
      $display("ERROR at %0t ns: %s", $time, what);
      mismatches++;
   endtask

   function automatic tip_reading_type apply_command(lin_cmd_type c);
      tip_reading_type r;
      int n, t, i, span, off, dt;
      bit found;
      r.tip = '0;
      r.ok = 1'b0;
      case (c.cmd)
         pwl_lin_pkg::CMD_CONVERT: begin
            if (tbl_valid && tbl_used != 0) begin
               n = (int'(tbl_used) > pwl_lin_pkg::MAX_POINTS) ? pwl_lin_pkg::MAX_POINTS
                                                              : int'(tbl_used);
               if (c.raw <= tbl_raw[0]) begin
                  t = int'(tbl_tip[0]);
               end else if (c.raw >= tbl_raw[n-1]) begin
                  t = int'(tbl_tip[n-1]);
               end else begin
                  t = int'(tbl_tip[0]);
                  found = 1'b0;
                  for (i = 1; i < n; i++) begin
                     if (!found && c.raw <= tbl_raw[i]) begin
                        found = 1'b1;
                        span = int'(tbl_raw[i]) - int'(tbl_raw[i-1]);
                        off = int'(c.raw) - int'(tbl_raw[i-1]);
                        dt = int'(tbl_tip[i]) - int'(tbl_tip[i-1]);
                        if (span <= 0) begin
                           t = int'(tbl_tip[i]);
                        end else begin
                           if (off < 0) off = 0;
                           t = int'(tbl_tip[i-1]) + (dt * off) / span;
                        end
                     end
                  end
               end
               t = t + int'($signed(c.amb)) - int'(ref_amb);
               if (t < 0) t = 0;
               if (t > int'(max_tip)) t = int'(max_tip);
               r.tip = pwl_lin_pkg::tip_type'(t);
               r.ok = 1'b1;
            end
         end
         pwl_lin_pkg::CMD_WRITE_POINT: begin
            if (int'(c.idx) < pwl_lin_pkg::MAX_POINTS) begin
               tbl_raw[c.idx] = c.raw;
               tbl_tip[c.idx] = c.ptemp;
               r.ok = 1'b1;
            end
         end
         pwl_lin_pkg::CMD_SET_COUNT: begin
            if (int'(c.cnt) <= pwl_lin_pkg::MAX_POINTS) begin
               tbl_used = c.cnt;
               tbl_valid = c.nv;
               r.ok = c.nv;
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            taken.cmd = req_cmd;
            taken.raw = req_raw_reading;
            taken.amb = req_ambient_temp;
            taken.idx = req_point_index;
            taken.ptemp = req_point_temp;
            taken.cnt = req_new_point_count;
            taken.nv = req_new_valid;
            expected_readings.push_back(apply_command(taken));
            void'(pending_cmds.pop_front());
            case (taken.cmd)
               pwl_lin_pkg::CMD_CONVERT:     n_convert++;
               pwl_lin_pkg::CMD_WRITE_POINT: n_point++;
               pwl_lin_pkg::CMD_SET_COUNT:   n_count++;
               default:                      n_other++;
            endcase
            if (gaps_on && $urandom_range(0, 3) == 0) idle_left = $urandom_range(1, 13);
         end
         if (!start || !busy) begin
            if (idle_left != 0) begin
               start <= 1'b0;
               idle_left--;
            end else if (pending_cmds.size() != 0) begin
               start <= 1'b1;
               req_cmd <= pending_cmds[0].cmd;
               req_raw_reading <= pending_cmds[0].raw;
               req_ambient_temp <= pending_cmds[0].amb;
               req_point_index <= pending_cmds[0].idx;
               req_point_temp <= pending_cmds[0].ptemp;
               req_new_point_count <= pending_cmds[0].cnt;
               req_new_valid <= pending_cmds[0].nv;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_readings.size() == 0) begin
            flag_mismatch($sformatf("result beat with nothing pending: tip %0d ok %0b",
                                    rsp_tip_temp, rsp_ok));
         end else begin
            want = expected_readings.pop_front();
            checked++;
            if (rsp_tip_temp !== want.tip)
               flag_mismatch($sformatf("tip_temp %0d, expected %0d", rsp_tip_temp, want.tip));
            if (rsp_ok !== want.ok)
               flag_mismatch($sformatf("ok %0b, expected %0b", rsp_ok, want.ok));
         end
      end
   end

   function automatic lin_cmd_type random_item();
      lin_cmd_type c;
      c.cmd = pwl_lin_pkg::cmd_type'($urandom);
      c.raw = pwl_lin_pkg::raw_type'($urandom);
      c.amb = pwl_lin_pkg::amb_type'($urandom);
      c.idx = pwl_lin_pkg::idx_type'($urandom);
      c.ptemp = pwl_lin_pkg::tip_type'($urandom);
      c.cnt = pwl_lin_pkg::cnt_type'($urandom);
      c.nv = 1'($urandom);
      return c;
   endfunction

   task automatic push_convert(pwl_lin_pkg::raw_type raw, pwl_lin_pkg::amb_type amb);
      lin_cmd_type c;
      c = random_item();
      c.cmd = pwl_lin_pkg::CMD_CONVERT;
      c.raw = raw;
      c.amb = amb;
      pending_cmds.push_back(c);
   endtask

   task automatic push_point(pwl_lin_pkg::idx_type idx, pwl_lin_pkg::raw_type raw,
                             pwl_lin_pkg::tip_type temp);
      lin_cmd_type c;
      c = random_item();
      c.cmd = pwl_lin_pkg::CMD_WRITE_POINT;
      c.idx = idx;
      c.raw = raw;
      c.ptemp = temp;
      pending_cmds.push_back(c);
   endtask

   task automatic push_count(pwl_lin_pkg::cnt_type cnt, logic nv);
      lin_cmd_type c;
      c = random_item();
      c.cmd = pwl_lin_pkg::CMD_SET_COUNT;
      c.cnt = cnt;
      c.nv = nv;
      pending_cmds.push_back(c);
   endtask

   task automatic write_reg(pwl_lin_pkg::csr_idx_type idx, pwl_lin_pkg::tip_type val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == pwl_lin_pkg::REG_REF_AMBIENT) ref_amb = pwl_lin_pkg::ref_type'(val);
      else max_tip = val;
      n_csr++;
   endtask

   task automatic settle();
      int waited;
      while (pending_cmds.size() != 0) @(posedge clock);
      waited = 0;
      while (expected_readings.size() != 0 && waited < RESULT_WAIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_readings.size() != 0) begin
         flag_mismatch($sformatf("%0d results never arrived", expected_readings.size()));
         expected_readings.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(int budget);
      pwl_lin_pkg::raw_type lvl [pwl_lin_pkg::MAX_POINTS];
      pwl_lin_pkg::raw_type raw;
      int made, np, k, seg, r, t, a;
      made = 0;
      while (made < budget) begin
         np = $urandom_range(2, pwl_lin_pkg::MAX_POINTS);
         r = $urandom_range(0, 3000);
         t = $urandom_range(0, 2000);
         for (k = 0; k < np; k++) begin
            lvl[k] = pwl_lin_pkg::raw_type'(r);
            if ($urandom_range(0, 3) == 0) t = $urandom_range(0, 8191);
            else t = (t + $urandom_range(0, 900)) % 8192;
            push_point(pwl_lin_pkg::idx_type'(k), lvl[k], pwl_lin_pkg::tip_type'(t));
            r = r + $urandom_range(1, ($urandom_range(0, 3) == 0) ? 16 : 7000);
         end
         push_count(pwl_lin_pkg::cnt_type'(np), $urandom_range(0, 7) != 0);
         made += np + 1;
         for (k = $urandom_range(10, 40); k > 0; k--) begin
            if ($urandom_range(0, 5) == 0) begin
               pending_cmds.push_back(random_item());
               made++;
            end
            case ($urandom_range(0, 7))
               0: raw = lvl[$urandom_range(0, np - 1)];
               1: raw = pwl_lin_pkg::raw_type'($urandom_range(0, lvl[0]));
               2: raw = pwl_lin_pkg::raw_type'($urandom_range(lvl[np-1], 65535));
               3: raw = pwl_lin_pkg::raw_type'($urandom);
               default: begin
                  seg = $urandom_range(1, np - 1);
                  raw = pwl_lin_pkg::raw_type'($urandom_range(lvl[seg-1], lvl[seg]));
               end
            endcase
            if ($urandom_range(0, 7) == 0) a = $urandom;
            else a = int'($urandom_range(0, 1650)) - 400;
            push_convert(raw, pwl_lin_pkg::amb_type'(a));
            made++;
         end
      end
      settle();
   endtask

   initial begin
      lin_cmd_type c;
      tbl_raw = pwl_lin_pkg::RESET_RAW;
      tbl_tip = pwl_lin_pkg::RESET_TIP;
      tbl_used = pwl_lin_pkg::RESET_USED;
      tbl_valid = 1'b0;
      ref_amb = pwl_lin_pkg::RESET_REF_AMBIENT;
      max_tip = pwl_lin_pkg::RESET_MAX_TIP;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Default curve, first marked invalid, then end points, clamps and
      // the rejected and empty table cases.
      push_convert(16'd2000, pwl_lin_pkg::amb_type'(250));
      push_count(pwl_lin_pkg::cnt_type'(8), 1'b1);
      push_convert(16'd0, pwl_lin_pkg::amb_type'(250));
      push_convert(16'd420, pwl_lin_pkg::amb_type'(250));
      push_convert(16'd1000, pwl_lin_pkg::amb_type'(250));
      push_convert(16'd1160, pwl_lin_pkg::amb_type'(250));
      push_convert(16'd4520, pwl_lin_pkg::amb_type'(250));
      push_convert(16'hFFFF, pwl_lin_pkg::amb_type'(250));
      push_convert(16'd0, pwl_lin_pkg::amb_type'(-2048));
      push_convert(16'hFFFF, pwl_lin_pkg::amb_type'(2047));
      push_convert(16'd3000, pwl_lin_pkg::amb_type'(-400));
      push_convert(16'd3000, pwl_lin_pkg::amb_type'(1250));
      push_count(pwl_lin_pkg::cnt_type'(9), 1'b1);
      push_count(pwl_lin_pkg::cnt_type'(15), 1'b0);
      push_count(pwl_lin_pkg::cnt_type'(0), 1'b1);
      push_convert(16'd2000, pwl_lin_pkg::amb_type'(250));
      push_count(pwl_lin_pkg::cnt_type'(8), 1'b0);
      push_convert(16'd2000, pwl_lin_pkg::amb_type'(250));
      c = random_item();
      c.cmd = CMD_UNKNOWN;
      pending_cmds.push_back(c);
      push_point(pwl_lin_pkg::idx_type'(1), 16'd1160, 13'd100);
      push_count(pwl_lin_pkg::cnt_type'(8), 1'b1);
      push_convert(16'd800, pwl_lin_pkg::amb_type'(250));
      push_point(pwl_lin_pkg::idx_type'(7), 16'hFFFF, 13'h1FFF);
      push_point(pwl_lin_pkg::idx_type'(2), 16'd1000, 13'd3000);
      push_convert(16'd1200, pwl_lin_pkg::amb_type'(250));
      push_convert(16'd40000, pwl_lin_pkg::amb_type'(250));
      settle();

      write_reg(pwl_lin_pkg::REG_REF_AMBIENT, pwl_lin_pkg::tip_type'(0));
      write_reg(pwl_lin_pkg::REG_MAX_TIP, pwl_lin_pkg::tip_type'(8191));
      run_phase(80);

      write_reg(pwl_lin_pkg::REG_REF_AMBIENT, pwl_lin_pkg::tip_type'(1023));
      write_reg(pwl_lin_pkg::REG_MAX_TIP, pwl_lin_pkg::tip_type'(0));
      run_phase(50);

      write_reg(pwl_lin_pkg::REG_REF_AMBIENT, pwl_lin_pkg::tip_type'($urandom_range(0, 1023)));
      write_reg(pwl_lin_pkg::REG_MAX_TIP, pwl_lin_pkg::tip_type'($urandom));
      run_phase(95);

      write_reg(pwl_lin_pkg::REG_MAX_TIP, pwl_lin_pkg::tip_type'($urandom_range(1000, 8191)));
      write_reg(pwl_lin_pkg::REG_REF_AMBIENT, pwl_lin_pkg::tip_type'($urandom_range(0, 1000)));
      run_phase(95);

      // The closing phase sends beats back to back.
      gaps_on = 1'b0;
      write_reg(pwl_lin_pkg::REG_REF_AMBIENT,
                pwl_lin_pkg::tip_type'(pwl_lin_pkg::RESET_REF_AMBIENT));
      write_reg(pwl_lin_pkg::REG_MAX_TIP, pwl_lin_pkg::RESET_MAX_TIP);
      run_phase(85);

      $display("Covered %0d conversions, %0d point writes, %0d count updates and %0d other",
               n_convert, n_point, n_count, n_other);
      $display("commands over %0d register writes; %0d results compared, %0d mismatches.",
               n_csr, checked, mismatches);
      if (mismatches == 0) begin
         $display("piecewise_linear_temp_linearizer: match");
      end else begin
         $display("piecewise_linear_temp_linearizer: mismatch");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("Run stopped by the time limit.");
      $display("piecewise_linear_temp_linearizer: mismatch");
      $finish;
   end

endmodule

@@ piecewise_linear_temp_linearizer.f @@
src/pwl_lin_pkg.sv
src/pwl_lin_dp.sv
src/pwl_lin_ctrl.sv
src/piecewise_linear_temp_linearizer.sv
tb/piecewise_linear_temp_linearizer_test.sv
